// File: sv/sorted_list_table_assert.svh
// ----------------------------------------------------------------------------
// sorted_list_table_assert.svh
// Assertion macros for the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define SLT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_list_table: same-cycle check failed");

// Next-cycle implication, checked on every clk edge outside reset.
`define SLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_list_table: next-cycle check failed");

`endif

// File: sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types and codes for the sorted key table.
// ----------------------------------------------------------------------------
package slt_pkg;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_DELETE = 2'd1;
  localparam mode_t MODE_FIND   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_ABSENT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

// File: sv/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sorted_list_table.sv
// ----------------------------------------------------------------------------
// sorted_list_table
// Sorted table of signed 32-bit keys with insert, delete and find.
// ----------------------------------------------------------------------------
// Keys live in one RAM in ascending order; a small sequencer drives its one
// read and one write port. A request first runs a binary search for the
// first entry not less than the key (each probe issues the address in
// S_SRCH and compares the registered read data in S_SCMP), then, for an
// accepted insert or delete, moves every later entry one slot, one entry
// per cycle with the read of the next entry overlapped with the write of
// the last. in_stall is high for the whole request. The result sits in an
// output register, so the next word is taken while a result still waits
// downstream. No clearing pass is run after reset: only entries below the
// count are ever read. Duplicate keys are kept; an insert lands in front
// of existing copies and a delete removes the lowest copy. Mode code 3
// acts as find.
// ----------------------------------------------------------------------------
`include "sorted_list_table_assert.svh"

module sorted_list_table #(
  parameter int DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  slt_pkg::mode_t        mode,
  input  logic signed [31:0]    key,
  output logic                  out_valid,
  input  logic                  out_stall,
  output slt_pkg::status_t      status,
  output logic                  found,
  output logic [6:0]            position,
  output logic [7:0]            entry_count,
  output logic                  is_full,
  output logic                  is_empty
);

  import slt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);               // holds 0..DEPTH
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // RAM index

  state_t state, state_next;

  // request
  mode_t              mode_r, mode_r_next;
  logic signed [31:0] key_r, key_r_next;

  // table count
  logic [CW-1:0] count, count_next;

  // search window and last probe
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [AW-1:0] mid, mid_next;
  logic          eq, eq_next;      // entry at hi equals key
  status_t       status_r, status_r_next;

  // shift control
  logic          dir_up, dir_up_next;  // insert moves entries up
  logic [CW-1:0] cur, cur_next;        // next entry to read
  logic          more, more_next;      // reads still to issue
  logic          pend, pend_next;      // read data waiting to be written
  logic [AW-1:0] pidx, pidx_next;      // index of that read

  // output register
  logic out_valid_next;
  logic out_load;

  // RAM port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  // decision terms
  logic [AW-1:0] mid_calc;
  logic          search_end;
  logic          ins_ok, del_ok;

  slt_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign mid_calc   = AW'(lo + ((hi - lo) >> 1));
  assign search_end = (lo >= hi);
  assign ins_ok     = (mode_r == MODE_INSERT) && (count < CW'(DEPTH));
  assign del_ok     = (mode_r == MODE_DELETE) && (count != '0) && eq;
  assign out_load   = (state == S_DONE) && (!out_valid || !out_stall);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SRCH;
      end
      S_SRCH: begin
        if (!search_end)          state_next = S_SCMP;
        else if (ins_ok || del_ok) state_next = S_SHIFT;
        else                      state_next = S_DONE;
      end
      S_SCMP: begin
        state_next = S_SRCH;
      end
      S_SHIFT: begin
        if (!more && !pend) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    mode_r_next    = mode_r;
    key_r_next     = key_r;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    eq_next        = eq;
    status_r_next  = status_r;
    dir_up_next    = dir_up;
    cur_next       = cur;
    more_next      = more;
    pend_next      = pend;
    pidx_next      = pidx;
    in_stall       = (state != S_IDLE);
    raddr          = mid;
    we             = 1'b0;
    waddr          = pidx;
    wdata          = rdata;
    out_valid_next = out_valid && out_stall;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          mode_r_next = mode;
          key_r_next  = key;
          lo_next     = '0;
          hi_next     = count;
          eq_next     = 1'b0;
        end
      end
      S_SRCH: begin
        if (!search_end) begin
          mid_next = mid_calc;
          raddr    = mid_calc;
        end else begin
          pend_next = 1'b0;
          case (mode_r)
            MODE_INSERT: begin
              if (!ins_ok) begin
                status_r_next = ST_FULL;
              end else begin
                status_r_next = ST_DONE;
                count_next    = count + 1'b1;
                dir_up_next   = 1'b1;
                cur_next      = count - 1'b1;
                more_next     = (lo < count);
              end
            end
            MODE_DELETE: begin
              if (count == '0) begin
                status_r_next = ST_EMPTY;
              end else if (!eq) begin
                status_r_next = ST_ABSENT;
              end else begin
                status_r_next = ST_DONE;
                count_next    = count - 1'b1;
                dir_up_next   = 1'b0;
                cur_next      = lo + 1'b1;
                more_next     = ((CW + 1)'(lo) + 1'b1) < (CW + 1)'(count);
              end
            end
            default: begin
              status_r_next = eq ? ST_DONE : ST_ABSENT;
            end
          endcase
        end
      end
      S_SCMP: begin
        if ($signed(rdata) < key_r) begin
          lo_next = CW'(mid) + 1'b1;
        end else begin
          hi_next = CW'(mid);
          eq_next = (rdata == key_r);
        end
      end
      S_SHIFT: begin
        if (pend) begin
          we    = 1'b1;
          waddr = dir_up ? (pidx + 1'b1) : (pidx - 1'b1);
          wdata = rdata;
        end
        if (more) begin
          raddr     = cur[AW-1:0];
          pend_next = 1'b1;
          pidx_next = cur[AW-1:0];
          if (dir_up) begin
            if (cur == lo) more_next = 1'b0;
            else           cur_next  = cur - 1'b1;
          end else begin
            if (cur == count) more_next = 1'b0;
            else              cur_next  = cur + 1'b1;
          end
        end else begin
          pend_next = 1'b0;
        end
        // last cycle: drop the new key into its slot
        if (!more && !pend && dir_up) begin
          we    = 1'b1;
          waddr = lo[AW-1:0];
          wdata = key_r;
        end
      end
      S_DONE: begin
        if (out_load) out_valid_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      more      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      more      <= more_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_r_next;
    key_r    <= key_r_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    eq       <= eq_next;
    status_r <= status_r_next;
    dir_up   <= dir_up_next;
    cur      <= cur_next;
    pidx     <= pidx_next;
    if (out_load) begin
      status      <= status_r;
      found       <= eq;
      position    <= (status_r == ST_DONE) ? 7'(lo) : 7'd0;
      entry_count <= 8'(count);
      is_full     <= (count == CW'(DEPTH));
      is_empty    <= (count == '0);
    end
  end

  // Checks
  `SLT_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `SLT_ASSERT_NXT(a_accept_starts_search, in_valid && !in_stall, state == S_SRCH)
  `SLT_ASSERT_IMP(a_write_only_in_shift, we, state == S_SHIFT)
  `SLT_ASSERT_IMP(a_probe_in_window, state == S_SCMP, CW'(mid) < hi)
  `SLT_ASSERT_IMP(a_full_reject_flag, out_valid && status == ST_FULL, is_full)

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: sorted key table testbench
// Drives insert, delete and find words into sorted_list_table, predicts each
// result with a local table model and compares every result field in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int    TABLE_DEPTH = 128;
  localparam mode_t MODE_SPARE  = 2'd3;   // unused code, behaves as find
  localparam int    HOLD_CYCLES = 600;    // long receiver hold-off
  localparam int    TAIL_CYCLES = 200;    // beyond the worst request time

  // One request word and one result word.
  typedef struct packed {
    mode_t              op;
    logic signed [31:0] key;
  } table_req_t;

  typedef struct packed {
    status_t    status;
    logic       found;
    logic [6:0] position;
    logic [7:0] entry_count;
    logic       is_full;
    logic       is_empty;
  } table_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mode_t              mode = MODE_FIND;
  logic signed [31:0] key = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  status_t            status;
  logic               found;
  logic [6:0]         position;
  logic [7:0]         entry_count;
  logic               is_full;
  logic               is_empty;

  sorted_list_table #(.DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found(found), .position(position),
    .entry_count(entry_count), .is_full(is_full), .is_empty(is_empty)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Words waiting for the driver, and results waiting for the DUT.
  table_req_t         pending_reqs[$];
  table_result_t      expected_results[$];

  // Generator's view of the table contents once all queued words are done.
  // Order does not matter here, only which keys are present.
  logic signed [31:0] gen_pool[$];

  // Predictor state: the table as the DUT should hold it right now.
  logic signed [31:0] shadow_keys[TABLE_DEPTH];
  int unsigned        shadow_count = 0;

  int  tx_idle_pct   = 0;
  int  rx_stall_pct  = 0;
  int  rx_hold_req   = 0;   // bumped by the sequence to ask for a hold-off
  int  rx_hold_seen  = 0;
  int  rx_hold_left  = 0;
  logic in_taken     = 1'b0;

  int  n_queued      = 0;
  int  n_accepted    = 0;
  int  n_errors      = 0;
  int  n_done        = 0;
  int  n_full_rej    = 0;
  int  n_empty_rej   = 0;
  int  n_absent      = 0;
  int  n_dup_ins     = 0;
  int  n_hit_full    = 0;

  // --------------------------------------------------------------------------
  // Table predictor. Lower bound is a linear scan: the first stored key that
  // is not less than k (signed). Insert goes in front of equal keys, delete
  // takes the lowest copy, mode 3 falls into the find branch.
  // --------------------------------------------------------------------------
  function automatic table_result_t predict_table(mode_t op, logic signed [31:0] k);
    table_result_t r;
    int unsigned   slot;
    logic          hit;
    slot = 0;
    while (slot < shadow_count && shadow_keys[slot] < k)
      slot++;
    hit = (slot < shadow_count) && (shadow_keys[slot] == k);
    r.status   = ST_DONE;
    r.found    = hit;
    r.position = '0;
    case (op)
      MODE_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > slot; i--)
            shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[slot] = k;
          shadow_count++;
          r.position = slot[6:0];
        end
      end
      MODE_DELETE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (!hit) begin
          r.status = ST_ABSENT;
        end else begin
          for (int i = slot; i + 1 < shadow_count; i++)
            shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          r.position = slot[6:0];
        end
      end
      default: begin
        if (hit) r.position = slot[6:0];
        else     r.status = ST_ABSENT;
      end
    endcase
    r.entry_count = shadow_count[7:0];
    r.is_full     = (shadow_count == TABLE_DEPTH);
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got_v);
    if (want != got_v) begin
      n_errors++;
      $display("%0d ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got_v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: new words go out at the falling edge. A word stays put until the
  // rising edge that takes it (in_taken), then the next one may follow.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    table_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        mode     <= req.op;
        key      <= req.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here when the
  // sequence asks for one.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, check a taken result against the oldest
  // prediction first, then predict for a word taken at the same edge (its
  // own result can only come later).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0d ns: unexpected result, expected none, got status %0d count %0d",
                   $time, status, entry_count);
        end else begin
          want = expected_results.pop_front();
          check_field("status",      want.status,      status);
          check_field("found",       want.found,       found);
          check_field("position",    want.position,    position);
          check_field("entry_count", want.entry_count, entry_count);
          check_field("is_full",     want.is_full,     is_full);
          check_field("is_empty",    want.is_empty,    is_empty);
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_table(mode, key);
        expected_results.push_back(want);
        n_accepted++;
        case (want.status)
          ST_DONE:   n_done++;
          ST_FULL:   n_full_rej++;
          ST_EMPTY:  n_empty_rej++;
          default:   n_absent++;
        endcase
        if (mode == MODE_INSERT && want.found && want.status == ST_DONE) n_dup_ins++;
        if (want.is_full) n_hit_full++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(mode_t op, logic signed [31:0] k);
    table_req_t req;
    int         idx;
    req.op  = op;
    req.key = k;
    pending_reqs.push_back(req);
    n_queued++;
    if (op == MODE_INSERT) begin
      if (gen_pool.size() < TABLE_DEPTH) gen_pool.push_back(k);
    end else if (op == MODE_DELETE) begin
      idx = -1;
      foreach (gen_pool[i])
        if (idx < 0 && gen_pool[i] == k) idx = i;
      if (idx >= 0) gen_pool.delete(idx);
    end
  endtask

  // Mostly keys already stored or near zero, so hits and duplicates are
  // common; the rest are extremes and full-range values.
  function automatic logic signed [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45 && gen_pool.size() > 0)
      return gen_pool[$urandom_range(gen_pool.size() - 1)];
    if (sel < 65)
      return $signed($urandom_range(16)) - 8;
    if (sel < 75) begin
      case ($urandom_range(5))
        0:       return 32'sh8000_0000;
        1:       return 32'sh8000_0001;
        2:       return 32'sh7FFF_FFFF;
        3:       return 32'sh7FFF_FFFE;
        4:       return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic queue_random(int ins_pct, int del_pct);
    int    sel;
    mode_t op;
    sel = $urandom_range(99);
    if (sel < ins_pct)                op = MODE_INSERT;
    else if (sel < ins_pct + del_pct) op = MODE_DELETE;
    else if ($urandom_range(4) == 0)  op = MODE_SPARE;
    else                              op = MODE_FIND;
    queue_req(op, pick_key());
  endtask

  // Sender pauses here until every queued word is taken and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-table cases, key extremes, duplicates, spare mode.
    queue_req(MODE_FIND,   32'sd0);
    queue_req(MODE_DELETE, 32'sd5);
    queue_req(MODE_SPARE,  32'sd7);
    queue_req(MODE_INSERT, 32'sd0);
    queue_req(MODE_INSERT, 32'sh7FFF_FFFF);
    queue_req(MODE_INSERT, 32'sh8000_0000);
    queue_req(MODE_INSERT, -32'sd1);
    queue_req(MODE_INSERT, 32'sd1);
    queue_req(MODE_INSERT, 32'sd0);
    queue_req(MODE_INSERT, 32'sh7FFF_FFFF);
    queue_req(MODE_FIND,   32'sd0);
    queue_req(MODE_FIND,   32'sh8000_0000);
    queue_req(MODE_FIND,   32'sh7FFF_FFFF);
    queue_req(MODE_FIND,   32'sd2);
    queue_req(MODE_SPARE,  32'sd1);
    queue_req(MODE_DELETE, 32'sd3);
    queue_req(MODE_DELETE, 32'sd0);
    queue_req(MODE_DELETE, 32'sh8000_0000);
    queue_req(MODE_DELETE, 32'sh7FFF_FFFF);
    queue_req(MODE_DELETE, 32'sh7FFF_FFFF);
    queue_req(MODE_FIND,   32'sh7FFF_FFFF);
    queue_req(MODE_INSERT, 32'sh5555_5555);
    queue_req(MODE_INSERT, 32'shAAAA_AAAA);
    wait_drained();

    // Balanced mix, no idling.
    repeat (150) queue_random(50, 25);
    wait_drained();

    // Fill to full and push inserts past it, sender mostly idle.
    tx_idle_pct = 85;
    while (gen_pool.size() < TABLE_DEPTH) queue_random(85, 5);
    repeat (25) queue_random(70, 5);
    wait_drained();

    // Drain to empty and keep deleting, receiver mostly stalled.
    tx_idle_pct  = 0;
    rx_stall_pct = 85;
    while (gen_pool.size() > 0) queue_random(5, 85);
    repeat (15) queue_random(5, 80);
    wait_drained();

    // Back-pressure: long hold-off while words keep coming, so the output
    // register fills and in_stall has to hold the sender.
    rx_stall_pct = 0;
    rx_hold_req++;
    repeat (8) queue_random(60, 20);
    wait_drained();

    // Mix with both sides idling a third of the time.
    tx_idle_pct  = 34;
    rx_stall_pct = 34;
    repeat (250) queue_random(50, 30);
    wait_drained();

    // Second fill at full rate, then drain under moderate idling.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (gen_pool.size() < TABLE_DEPTH) queue_random(90, 5);
    repeat (20) queue_random(60, 10);
    wait_drained();
    tx_idle_pct  = 34;
    rx_stall_pct = 34;
    while (gen_pool.size() > 0) queue_random(10, 80);
    wait_drained();

    // Remaining words: receiver-heavy stalls, then sender-heavy idling.
    tx_idle_pct  = 0;
    rx_stall_pct = 85;
    repeat (150) queue_random(55, 25);
    wait_drained();
    tx_idle_pct  = 85;
    rx_stall_pct = 0;
    while (n_queued < 1550) queue_random(55, 25);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d words: %0d done, %0d full rejects, %0d empty rejects, %0d misses",
             n_accepted, n_done, n_full_rej, n_empty_rej, n_absent);
    $display("Duplicate inserts: %0d, results with table full: %0d, mismatches: %0d",
             n_dup_ins, n_hit_full, n_errors);
    if (n_errors == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog, well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("Watchdog expired with %0d results outstanding", expected_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
